FILE: src/u8lt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8lt_pkg: shared types and constants of the UTF-8 Latin transliterator
// Holds the lookahead kinds, the command format passed from the front to the
// back, the register indexes and the code point folding function.
// ----------------------------------------------------------------------------
package u8lt_pkg;

  // Lookahead byte held by the front
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_BSLASH = 2'd1,
    KIND_LEAD   = 2'd2
  } kind_t;

  // Command classes sent from the front to the back
  typedef enum logic [2:0] {
    OP_COPY        = 3'd0,  // emit the byte
    OP_NEWLINE     = 3'd1,  // emit optional return, then newline
    OP_BSLASH      = 3'd2,  // emit a lone backslash
    OP_BSLASH_COPY = 3'd3,  // emit a backslash, then the byte
    OP_CODE        = 3'd4   // fold the code point
  } op_t;

  localparam int CP_W = 11;

  typedef struct packed {
    op_t             op;
    logic [CP_W-1:0] data;  // byte in the low bits, or a code point
    logic            last;
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_LATIN1_MODE  = 2'd0;
  localparam logic [1:0] REG_CRLF_MODE    = 2'd1;
  localparam logic [1:0] REG_NEWLINE_CODE = 2'd2;
  localparam logic [1:0] REG_RETURN_CODE  = 2'd3;

  localparam logic [7:0] NEWLINE_RESET = 8'd155;
  localparam logic [7:0] RETURN_RESET  = 8'd13;

  // Byte constants
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_UNDER  = 8'h5F;
  localparam logic [7:0] LEAD_LOW    = 8'hC0;
  localparam logic [7:0] LEAD_HIGH   = 8'hDF;
  localparam logic [CP_W-1:0] LATIN_LOW  = 11'h0A0;
  localparam logic [CP_W-1:0] LATIN_HIGH = 11'h0FF;

  // Command queue depth, a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Polish letters; zero when the code point is not one of them
  function automatic logic [7:0] fold_polish(input logic [CP_W-1:0] cp);
    logic [7:0] r;
    case (cp)
      11'h105: r = 8'h61;  // a
      11'h107: r = 8'h63;  // c
      11'h119: r = 8'h65;  // e
      11'h142: r = 8'h6C;  // l
      11'h144: r = 8'h6E;  // n
      11'h15B: r = 8'h73;  // s
      11'h17A: r = 8'h7A;  // z
      11'h17C: r = 8'h7A;  // z
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // German, French, Spanish and Italian letters; underscore otherwise
  function automatic logic [7:0] fold_western(input logic [CP_W-1:0] cp);
    logic [7:0] r;
    case (cp)
      11'h0F3, 11'h0F6, 11'h0F4, 11'h0F2: r = 8'h6F;  // o
      11'h0E4, 11'h0E0, 11'h0E2, 11'h0E1: r = 8'h61;  // a
      11'h0FC, 11'h0F9, 11'h0FB, 11'h0FA: r = 8'h75;  // u
      11'h0DF:                            r = 8'h73;  // sharp s
      11'h0E7:                            r = 8'h63;  // c
      11'h0E9, 11'h0E8, 11'h0EA, 11'h0EB: r = 8'h65;  // e
      11'h0EE, 11'h0EF, 11'h0ED, 11'h0EC: r = 8'h69;  // i
      11'h0F1:                            r = 8'h6E;  // n
      default:                            r = CHAR_UNDER;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] map_code(input logic [CP_W-1:0] cp, input logic latin1);
    logic [7:0] pol;
    logic [7:0] r;
    pol = fold_polish(cp);
    if (latin1 && cp >= LATIN_LOW && cp <= LATIN_HIGH) begin
      r = cp[7:0];
    end else if (pol != 8'h00) begin
      r = pol;
    end else if (latin1) begin
      r = CHAR_UNDER;
    end else begin
      r = fold_western(cp);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/u8lt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8lt_queue: command queue between front and back
// A few entries of flops with a fill count; the head is read combinationally.
// ----------------------------------------------------------------------------
module u8lt_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   wr_en,
  input  u8lt_pkg::cmd_t        wr_cmd,
  output logic                  q_full,
  input  wire                   rd_en,
  output u8lt_pkg::cmd_t        rd_cmd,
  output logic                  q_empty
);

  u8lt_pkg::cmd_t                    entries [u8lt_pkg::QDEPTH];
  logic [u8lt_pkg::QPTR_W-1:0]       wr_ptr;
  logic [u8lt_pkg::QPTR_W-1:0]       rd_ptr;
  logic [u8lt_pkg::QCNT_W-1:0]       count;

  assign q_full  = (count == u8lt_pkg::QCNT_W'(u8lt_pkg::QDEPTH));
  assign q_empty = (count == '0);
  assign rd_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr_en |-> !q_full)
    else $error("command written into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd_en |-> !q_empty)
    else $error("command read from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= u8lt_pkg::QCNT_W'(u8lt_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

FILE: src/u8lt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8lt_front: byte intake and classification
// Holds the one-byte lookahead and turns accepted bytes into commands.
// ----------------------------------------------------------------------------
module u8lt_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  wire  [7:0]            in_byte,
  input  wire                   in_last,
  input  wire                   q_full,
  output logic                  q_push,
  output u8lt_pkg::cmd_t        q_cmd
);

  u8lt_pkg::kind_t pending_kind;
  u8lt_pkg::kind_t pending_kind_next;
  logic [4:0]      pending_lead;
  logic [4:0]      pending_lead_next;
  logic            accept;
  logic            hold_bs;
  logic            hold_lead;
  logic            produce;

  assign accept    = push && !q_full;
  assign hold_bs   = !in_last && (in_byte == u8lt_pkg::CHAR_BSLASH);
  assign hold_lead = !in_last && (in_byte inside {[u8lt_pkg::LEAD_LOW:u8lt_pkg::LEAD_HIGH]});

  // Next lookahead
  always_comb begin
    pending_kind_next = pending_kind;
    pending_lead_next = pending_lead;
    if (accept) begin
      pending_kind_next = u8lt_pkg::KIND_NONE;
      if (!(pending_kind == u8lt_pkg::KIND_LEAD) &&
          !(pending_kind == u8lt_pkg::KIND_BSLASH && in_byte == u8lt_pkg::CHAR_N)) begin
        if (hold_bs) begin
          pending_kind_next = u8lt_pkg::KIND_BSLASH;
        end else if (hold_lead) begin
          pending_kind_next = u8lt_pkg::KIND_LEAD;
          pending_lead_next = in_byte[4:0];
        end
      end
    end
  end

  // Command for the byte on the inputs
  always_comb begin
    produce    = 1'b0;
    q_cmd.op   = u8lt_pkg::OP_COPY;
    q_cmd.data = {3'b000, in_byte};
    q_cmd.last = in_last;
    case (pending_kind)
      u8lt_pkg::KIND_BSLASH: begin
        produce = 1'b1;
        if (in_byte == u8lt_pkg::CHAR_N) begin
          q_cmd.op = u8lt_pkg::OP_NEWLINE;
        end else if (hold_bs || hold_lead) begin
          q_cmd.op = u8lt_pkg::OP_BSLASH;
        end else begin
          q_cmd.op = u8lt_pkg::OP_BSLASH_COPY;
        end
      end
      u8lt_pkg::KIND_LEAD: begin
        produce    = 1'b1;
        q_cmd.op   = u8lt_pkg::OP_CODE;
        q_cmd.data = {pending_lead, in_byte[5:0]};
      end
      default: begin
        produce = !(hold_bs || hold_lead);
      end
    endcase
  end

  assign q_push = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_kind <= u8lt_pkg::KIND_NONE;
    end else begin
      pending_kind <= pending_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    pending_lead <= pending_lead_next;
  end

  a_last_flushes: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> pending_kind == u8lt_pkg::KIND_NONE)
    else $error("lookahead left pending after the final byte");
  a_final_emits: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |-> q_push)
    else $error("final byte produced no command");

endmodule
`default_nettype wire

FILE: src/u8lt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8lt_back: command execution and result register
// Expands each command into one or two beats and holds them for the consumer.
// ----------------------------------------------------------------------------
module u8lt_back (
  input  wire                   clk,
  input  wire                   rst,
  input  u8lt_pkg::cmd_t        q_cmd,
  input  wire                   q_empty,
  output logic                  q_pop,
  input  wire                   latin1_mode,
  input  wire                   crlf_mode,
  input  wire  [7:0]            newline_code,
  input  wire  [7:0]            return_code,
  output logic                  empty,
  input  wire                   pop,
  output logic [7:0]            out_byte,
  output logic                  run_last,
  output logic                  text_end
);

  logic       out_valid;
  logic       second_valid;
  logic [7:0] second_byte;
  logic       second_last;
  logic       load;
  logic [7:0] first_b;
  logic [7:0] second_b;
  logic       two;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;
  assign q_pop = load && !second_valid && !q_empty;

  // Beats for the command at the head of the queue
  always_comb begin
    first_b  = q_cmd.data[7:0];
    second_b = q_cmd.data[7:0];
    two      = 1'b0;
    case (q_cmd.op)
      u8lt_pkg::OP_COPY: begin
        first_b = q_cmd.data[7:0];
      end
      u8lt_pkg::OP_NEWLINE: begin
        if (crlf_mode) begin
          first_b  = return_code;
          second_b = newline_code;
          two      = 1'b1;
        end else begin
          first_b = newline_code;
        end
      end
      u8lt_pkg::OP_BSLASH: begin
        first_b = u8lt_pkg::CHAR_BSLASH;
      end
      u8lt_pkg::OP_BSLASH_COPY: begin
        first_b = u8lt_pkg::CHAR_BSLASH;
        two     = 1'b1;
      end
      u8lt_pkg::OP_CODE: begin
        first_b = u8lt_pkg::map_code(q_cmd.data, latin1_mode);
      end
      default: begin
        first_b = q_cmd.data[7:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      second_valid <= 1'b0;
    end else if (load) begin
      if (second_valid) begin
        out_valid    <= 1'b1;
        second_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid    <= 1'b1;
        second_valid <= two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_valid) begin
        out_byte <= second_byte;
        run_last <= 1'b1;
        text_end <= second_last;
      end else if (!q_empty) begin
        out_byte    <= first_b;
        run_last    <= !two;
        text_end    <= q_cmd.last && !two;
        second_byte <= second_b;
        second_last <= q_cmd.last;
      end
    end
  end

  a_second_behind_first: assert property (@(posedge clk) disable iff (rst)
    second_valid |-> out_valid && !run_last)
    else $error("second beat waiting without its first beat");
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    second_valid && pop |=> out_valid && run_last)
    else $error("second beat not presented after the first");

endmodule
`default_nettype wire

FILE: src/utf8_latin_transliterator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_latin_transliterator_unit: two-byte UTF-8 to plain ASCII folding
// Byte stream in, byte stream out; backslash-n becomes a newline code and
// two-byte sequences fold to ASCII letters or an underscore, or pass through as Latin-1.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload                        direction
//  -------   ------------------   ----------------------------   ---------
//  input     push / full          in_byte, in_last               in
//  result    empty / pop          out_byte, run_last, text_end   out
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data            in
//
//  One byte is taken per cycle while the command queue has room. A byte that
//  makes two beats (backslash plus byte, or return plus newline in crlf mode)
//  holds the back end for both of its beats; the queue absorbs that burst.
//  An input beat is registered in the queue and then in the result register.
//  A full result register stalls the back end only; the front keeps taking
//  bytes until the queue fills. Reset clears the lookahead, the queue and the
//  result register, and loads the register defaults; no clearing pass.
//
module utf8_latin_transliterator_unit (
  input  wire        clk,
  input  wire        rst,
  // input channel
  input  wire        push,
  output logic       full,
  input  wire  [7:0] in_byte,
  input  wire        in_last,
  // result channel
  output logic       empty,
  input  wire        pop,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       text_end,
  // configuration channel
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [1:0] cfg_index,
  input  wire  [7:0] cfg_data
);

  // Configuration registers
  logic       latin1_mode;
  logic       crlf_mode;
  logic [7:0] newline_code;
  logic [7:0] return_code;

  // Front to queue, queue to back
  logic           q_push;
  u8lt_pkg::cmd_t q_wr_cmd;
  logic           q_full;
  logic           q_pop;
  u8lt_pkg::cmd_t q_rd_cmd;
  logic           q_empty;

  // Writes are always taken; the register file never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      latin1_mode  <= 1'b0;
      crlf_mode    <= 1'b0;
      newline_code <= u8lt_pkg::NEWLINE_RESET;
      return_code  <= u8lt_pkg::RETURN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        u8lt_pkg::REG_LATIN1_MODE:  latin1_mode  <= cfg_data[0];
        u8lt_pkg::REG_CRLF_MODE:    crlf_mode    <= cfg_data[0];
        u8lt_pkg::REG_NEWLINE_CODE: newline_code <= cfg_data;
        u8lt_pkg::REG_RETURN_CODE:  return_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off the producer only when the queue itself has no room.
  assign full = q_full;

  u8lt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd)
  );

  u8lt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_cmd  (q_wr_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_cmd  (q_rd_cmd),
    .q_empty (q_empty)
  );

  u8lt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_cmd        (q_rd_cmd),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .latin1_mode  (latin1_mode),
    .crlf_mode    (crlf_mode),
    .newline_code (newline_code),
    .return_code  (return_code),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .text_end     (text_end)
  );

  // A text end always closes the run of its input beat.
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    !empty && text_end |-> run_last)
    else $error("text end on a beat that is not the last of its run");

endmodule
`default_nettype wire
